// ===== design/first_fit_bin_packer_assert.svh =====
// ----------------------------------------------------------------------------
// first_fit_bin_packer_assert
// Assertion macros for the first-fit bin packer, clocked on clk, reset rst_n.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BIN_PACKER_ASSERT_SVH
`define FIRST_FIT_BIN_PACKER_ASSERT_SVH

// check a condition in the same cycle
`define FFBP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check a condition in the following cycle
`define FFBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ffbp_pkg.sv =====
// ----------------------------------------------------------------------------
// ffbp_pkg
// Shared constants and controller/datapath interface types of the packer.
// ----------------------------------------------------------------------------
package ffbp_pkg;

    localparam int MAX_BINS_DEF  = 64;
    localparam int FRAC_BITS_DEF = 16;

    typedef struct packed {
        logic load;
        logic hit;
        logic step;
        logic finish;
    } ffbp_cmd_t;

    typedef struct packed {
        logic scan_end;
        logic fits;
        logic out_free;
    } ffbp_status_t;

endpackage

// ===== design/first_fit_bin_packer.sv =====
// ----------------------------------------------------------------------------
// first_fit_bin_packer
// Online first-fit bin packing with a shared fill-level memory.
// ----------------------------------------------------------------------------
// Each weight goes into the lowest open bin whose fill plus the weight stays
// at or below the capacity; otherwise a new bin opens, and with all bins open
// the word is dropped and flagged no_room. One item is handled at a time: each
// open bin from bin 0 upward is read in a look state and tested in a check
// state until one fits or all open bins are tested, and the final step waits
// while an earlier result is still unaccepted in the output register. The
// input is ready again in the same cycle that the result is posted. The scan
// is set by the single registered read port of the fill-level memory. The
// next word is accepted while a result still waits in the output register. No
// clearing pass: after reset or a start flag the bin count is zero and each
// bin is written when opened.
// ----------------------------------------------------------------------------
`include "first_fit_bin_packer_assert.svh"

module first_fit_bin_packer
    import ffbp_pkg::*;
#(
    parameter int MAX_BINS  = MAX_BINS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int WEIGHT_W = FRAC_BITS + 1,
    localparam int IDX_W    = $clog2(MAX_BINS),
    localparam int CNT_W    = $clog2(MAX_BINS + 1),
    localparam int S_W      = ((WEIGHT_W + 1 + 7) / 8) * 8,
    localparam int M_W      = ((IDX_W + 3 + CNT_W + 7) / 8) * 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_W-1:0]      s_tdata,   // weight, start_set
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_W-1:0]      m_tdata,   // bin_index, opened_bin, oversize,
                                           // no_room, bins_in_use
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [WEIGHT_W-1:0] cfg_data   // bin_capacity
);

    ffbp_cmd_t        cmd;
    ffbp_status_t     status;
    logic [IDX_W-1:0] bin_index;
    logic             opened_bin;
    logic             oversize;
    logic             no_room;
    logic [CNT_W-1:0] bins_in_use;

    assign cfg_ready = 1'b1;

    ffbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ffbp_datapath #(
        .MAX_BINS  (MAX_BINS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_weight    (s_tdata[WEIGHT_W-1:0]),
        .in_start     (s_tdata[WEIGHT_W]),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .out_index    (bin_index),
        .out_opened   (opened_bin),
        .out_oversize (oversize),
        .out_no_room  (no_room),
        .out_in_use   (bins_in_use)
    );

    assign m_tdata = M_W'({bins_in_use, no_room, oversize, opened_bin, bin_index});

    `FFBP_ASSERT_NOW(a_drop_clean, m_tvalid && no_room,
        !opened_bin && bin_index == '0 && bins_in_use == CNT_W'(MAX_BINS),
        "dropped word must report a full set of bins and no placement")
    `FFBP_ASSERT_NOW(a_open_last, m_tvalid && opened_bin,
        CNT_W'(bin_index) + CNT_W'(1) == bins_in_use,
        "opened bin must be the last bin in use")
    `FFBP_ASSERT_NEXT(a_busy_after_load, cmd.load, !s_tready,
        "sequencer must be busy after taking a word")

endmodule

// ===== design/ffbp_ram.sv =====
// ----------------------------------------------------------------------------
// ffbp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffbp_ram
#(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64,
    localparam int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/ffbp_datapath.sv =====
// ----------------------------------------------------------------------------
// ffbp_datapath
// Fill-level memory, scan pointer, bin count, capacity and result register.
// ----------------------------------------------------------------------------
module ffbp_datapath
    import ffbp_pkg::*;
#(
    parameter int MAX_BINS  = MAX_BINS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int WEIGHT_W = FRAC_BITS + 1,
    localparam int IDX_W    = $clog2(MAX_BINS),
    localparam int CNT_W    = $clog2(MAX_BINS + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ffbp_cmd_t           cmd,
    output ffbp_status_t        status,
    input  logic [WEIGHT_W-1:0] in_weight,
    input  logic                in_start,
    input  logic                cfg_valid,
    input  logic [WEIGHT_W-1:0] cfg_data,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [IDX_W-1:0]    out_index,
    output logic                out_opened,
    output logic                out_oversize,
    output logic                out_no_room,
    output logic [CNT_W-1:0]    out_in_use
);

    logic [WEIGHT_W-1:0] cap_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    logic                over_reg;
    logic                found_reg;
    logic [CNT_W-1:0]    scan_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                valid_reg;
    logic [IDX_W-1:0]    index_reg;
    logic [IDX_W-1:0]    index_next;
    logic                opened_reg;
    logic                opened_next;
    logic                over_out_reg;
    logic                no_room_reg;
    logic                no_room_next;
    logic [CNT_W-1:0]    in_use_reg;

    logic [WEIGHT_W-1:0] fill;
    logic [WEIGHT_W:0]   sum;
    logic                room;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [WEIGHT_W-1:0] ram_wdata;

    ffbp_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (MAX_BINS)
    ) u_fill (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_reg[IDX_W-1:0]),
        .rdata (fill)
    );

    assign sum  = {1'b0, fill} + {1'b0, weight_reg};
    assign room = count_reg < CNT_W'(MAX_BINS);

    assign status.scan_end = scan_reg == count_reg;
    assign status.fits     = sum <= {1'b0, cap_reg};
    assign status.out_free = !valid_reg || m_tready;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = scan_reg[IDX_W-1:0];
        ram_wdata = sum[WEIGHT_W-1:0];
        if (cmd.hit)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.finish && !found_reg && room)
        begin
            ram_we    = 1'b1;
            ram_waddr = count_reg[IDX_W-1:0];
            ram_wdata = weight_reg;
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        index_next   = '0;
        opened_next  = 1'b0;
        no_room_next = 1'b0;
        if (found_reg)
        begin
            index_next = scan_reg[IDX_W-1:0];
        end
        else if (room)
        begin
            index_next  = count_reg[IDX_W-1:0];
            opened_next = 1'b1;
            count_next  = count_reg + CNT_W'(1);
        end
        else
        begin
            no_room_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= WEIGHT_W'(1) << FRAC_BITS;
            count_reg <= '0;
            scan_reg  <= '0;
            found_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                scan_reg  <= '0;
                found_reg <= 1'b0;
                if (in_start)
                begin
                    count_reg <= '0;
                end
            end
            if (cmd.step)
            begin
                scan_reg <= scan_reg + CNT_W'(1);
            end
            if (cmd.hit)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                count_reg <= count_next;
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            weight_reg <= in_weight;
            over_reg   <= in_weight > cap_reg;
        end
        if (cmd.finish)
        begin
            index_reg    <= index_next;
            opened_reg   <= opened_next;
            over_out_reg <= over_reg;
            no_room_reg  <= no_room_next;
            in_use_reg   <= count_next;
        end
    end

    assign m_tvalid     = valid_reg;
    assign out_index    = index_reg;
    assign out_opened   = opened_reg;
    assign out_oversize = over_out_reg;
    assign out_no_room  = no_room_reg;
    assign out_in_use   = in_use_reg;

endmodule

// ===== design/ffbp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffbp_ctrl
// Sequencer: take a word, scan open bins one by one, then post the result.
// ----------------------------------------------------------------------------
module ffbp_ctrl
    import ffbp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  ffbp_status_t status,
    output ffbp_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_LOOK   = 4'b0010,
        ST_CHECK  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (status.scan_end)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (status.fits)
                begin
                    cmd.hit    = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_LOOK;
                end
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
